@@ hw/rtl/fcp_pkg.sv @@
// shared types and constants for the framed command parser
`timescale 1ns / 1ps

package fcp_pkg;

  localparam int unsigned FRAME_LENGTH = 7;
  localparam int unsigned CNT_W        = $clog2(FRAME_LENGTH);
  localparam int unsigned REPLY_MAX    = 8;
  localparam int unsigned LEN_W        = $clog2(REPLY_MAX + 1);
  localparam int unsigned DUTY_W       = 13;
  localparam int unsigned STEP_W       = 6;

  localparam logic [7:0] HEAD_A        = 8'hFE;
  localparam logic [7:0] HEAD_B        = 8'hAB;
  localparam logic [7:0] REPLY_A       = 8'hD5;
  localparam logic [7:0] REPLY_B       = 8'h33;
  localparam logic [7:0] TEMP_LEN_BYTE = 8'h08;
  localparam logic [7:0] TYPE_CTRL     = 8'h01;
  localparam logic [7:0] TYPE_TEMP     = 8'h02;
  localparam logic [7:0] ACT_REPORT    = 8'h01;
  localparam logic [7:0] STATUS_OK     = 8'h00;
  localparam logic [7:0] STATUS_BADSUM = 8'h01;

  localparam logic [7:0] ACT_STOP  = 8'd0;
  localparam logic [7:0] ACT_FWD   = 8'd1;
  localparam logic [7:0] ACT_LEFT  = 8'd2;
  localparam logic [7:0] ACT_RIGHT = 8'd3;
  localparam logic [7:0] ACT_BACK  = 8'd4;
  localparam logic [7:0] ACT_SPEED = 8'd5;

  localparam logic [7:0] DIR_RESET = 8'h77;
  localparam logic [7:0] DIR_FWD   = 8'h55;
  localparam logic [7:0] DIR_LEFT  = 8'h66;
  localparam logic [7:0] DIR_RIGHT = 8'h99;
  localparam logic [7:0] DIR_BACK  = 8'hAA;

  localparam logic [7:0]        SPEED_TOP       = 8'd100;
  localparam logic [DUTY_W-1:0] DUTY_TOP        = 13'h1000;
  localparam logic [DUTY_W-1:0] DUTY_MIN_RESET  = 13'd2048;
  localparam logic [STEP_W-1:0] DUTY_STEP_RESET = 6'd20;
  localparam logic [DUTY_W-1:0] DUTY_INIT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    CFG_DUTY_MIN  = 2'd0,
    CFG_DUTY_STEP = 2'd1,
    CFG_DUTY_INIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rx_byte;
    logic [15:0] temperature;
  } item_t;

  typedef struct packed {
    logic              standby;
    logic [7:0]        direction;
    logic [DUTY_W-1:0] duty;
  } motor_t;

  // bytes[0] goes out first
  typedef struct packed {
    logic [REPLY_MAX-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
    motor_t                    motor;
  } reply_t;

endpackage

@@ hw/rtl/framed_command_parser_with_reply_unit.sv @@
// top level: input register, duty registers, parser and reply sender
//
//  channel | signals                                       | direction
//  in      | in_valid in_ready in_kind in_rx_byte in_temp.. | into block
//  out     | out_valid out_ready out_reply_byte .. duty     | out of block
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data         | into block
//
// an input beat is registered, then decoded; a reply frame of 7 or 8 bytes then
// leaves one byte per cycle from the reply shift register while out_ready is high.
// the input register holds each item while an earlier reply frame is being sent
// and passes it in the cycle the last byte of that frame leaves, so items follow
// at one per cycle while no reply is in progress.
// reset clears the frame hunt, loads both duties with 4096 and pins with 0x77.
// duty_initial is accepted on the cfg port but not stored; the duty after reset is 4096.
`timescale 1ns / 1ps

module framed_command_parser_with_reply_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [7:0]                  in_rx_byte,
  input  logic [15:0]                 in_temperature,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_reply_byte,
  output logic                        out_reply_last,
  output logic                        out_motor_standby,
  output logic [7:0]                  out_motor_direction,
  output logic [fcp_pkg::DUTY_W-1:0]  out_motor_duty,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [fcp_pkg::DUTY_W-1:0]  cfg_data
);

  fcp_pkg::item_t             item_r;
  logic                       item_vld_r;
  logic [fcp_pkg::DUTY_W-1:0] duty_min_r;
  logic [fcp_pkg::STEP_W-1:0] duty_step_r;
  logic                       tx_free, go, reply_en;
  fcp_pkg::reply_t            reply;

  assign go        = item_vld_r && tx_free;
  assign in_ready  = !item_vld_r || go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind        <= in_kind;
      item_r.rx_byte     <= in_rx_byte;
      item_r.temperature <= in_temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_min_r  <= fcp_pkg::DUTY_MIN_RESET;
      duty_step_r <= fcp_pkg::DUTY_STEP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fcp_pkg::CFG_DUTY_MIN:  duty_min_r  <= cfg_data;
        fcp_pkg::CFG_DUTY_STEP: duty_step_r <= cfg_data[fcp_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fcp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .item      (item_r),
    .duty_min  (duty_min_r),
    .duty_step (duty_step_r),
    .reply_en  (reply_en),
    .reply     (reply)
  );

  fcp_reply_tx u_reply_tx (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (reply_en),
    .reply               (reply),
    .free                (tx_free),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_reply_byte      (out_reply_byte),
    .out_reply_last      (out_reply_last),
    .out_motor_standby   (out_motor_standby),
    .out_motor_direction (out_motor_direction),
    .out_motor_duty      (out_motor_duty)
  );

endmodule

@@ hw/rtl/fcp_parser.sv @@
// frame hunt, command decode, motor state and reply frame build
`timescale 1ns / 1ps

module fcp_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  fcp_pkg::item_t               item,
  input  logic [fcp_pkg::DUTY_W-1:0]   duty_min,
  input  logic [fcp_pkg::STEP_W-1:0]   duty_step,
  output logic                         reply_en,
  output fcp_pkg::reply_t              reply
);

  logic [fcp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic [7:0]                 type_r, type_nxt;
  logic [7:0]                 act_r, act_nxt;
  logic [7:0]                 data_r, data_nxt;
  logic [fcp_pkg::DUTY_W-1:0] speed_r, speed_nxt;
  logic [fcp_pkg::DUTY_W-1:0] applied_r, applied_nxt;
  logic [7:0]                 dir_r, dir_nxt;
  logic                       standby_r, standby_nxt;

  logic        send_ctrl, send_temp;
  logic [7:0]  status, rep_act, b;
  logic [14:0] prod, dsum;
  logic [7:0]  ctrl_sum, temp_sum;

  function automatic logic [13:0] item_mul(input logic [fcp_pkg::STEP_W-1:0] s,
                                           input logic [7:0] d);
    item_mul = 14'(s) * 14'(d);
  endfunction

  assign b    = item.rx_byte;
  assign prod = 15'(item_mul(duty_step, data_r));
  assign dsum = {2'b00, duty_min} + prod;

  always_comb begin
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    type_nxt    = type_r;
    act_nxt     = act_r;
    data_nxt    = data_r;
    speed_nxt   = speed_r;
    applied_nxt = applied_r;
    dir_nxt     = dir_r;
    standby_nxt = standby_r;
    send_ctrl   = 1'b0;
    send_temp   = 1'b0;
    status      = fcp_pkg::STATUS_OK;
    rep_act     = act_r;

    if (item.kind) begin
      send_temp = 1'b1;
      rep_act   = fcp_pkg::ACT_REPORT;
    end else if (cnt_r == 3'd0) begin
      if (b == fcp_pkg::HEAD_A) begin
        sum_nxt = b;
        cnt_nxt = 3'd1;
      end
    end else if (cnt_r == 3'd1) begin
      if (b == fcp_pkg::HEAD_B) begin
        sum_nxt = sum_r + b;
        cnt_nxt = 3'd2;
      end else if (b == fcp_pkg::HEAD_A) begin
        sum_nxt = b;
        cnt_nxt = 3'd1;
      end else begin
        cnt_nxt = 3'd0;
      end
    end else if (cnt_r == 3'd2) begin
      if (b == 8'(fcp_pkg::FRAME_LENGTH)) begin
        sum_nxt = sum_r + b;
        cnt_nxt = 3'd3;
      end else begin
        cnt_nxt = 3'd0;
      end
    end else if (cnt_r < fcp_pkg::CNT_W'(fcp_pkg::FRAME_LENGTH - 1)) begin
      // body bytes: type, action, data
      sum_nxt = sum_r + b;
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd3) type_nxt = b;
      if (cnt_r == 3'd4) act_nxt = b;
      if (cnt_r == 3'd5) data_nxt = b;
    end else if (cnt_r == fcp_pkg::CNT_W'(fcp_pkg::FRAME_LENGTH - 1)) begin
      // checksum byte closes the frame
      cnt_nxt = 3'd0;
      if (sum_r != b) begin
        if (type_r == fcp_pkg::TYPE_CTRL) begin
          send_ctrl = 1'b1;
          status    = fcp_pkg::STATUS_BADSUM;
        end
        if (type_r == fcp_pkg::TYPE_TEMP) send_temp = 1'b1;
      end else if (type_r == fcp_pkg::TYPE_TEMP) begin
        send_temp = 1'b1;
      end else if (type_r == fcp_pkg::TYPE_CTRL) begin
        case (act_r)
          fcp_pkg::ACT_STOP: begin
            standby_nxt = 1'b0;
            send_ctrl   = 1'b1;
          end
          fcp_pkg::ACT_FWD, fcp_pkg::ACT_LEFT, fcp_pkg::ACT_RIGHT,
          fcp_pkg::ACT_BACK: begin
            case (act_r)
              fcp_pkg::ACT_FWD:   dir_nxt = fcp_pkg::DIR_FWD;
              fcp_pkg::ACT_LEFT:  dir_nxt = fcp_pkg::DIR_LEFT;
              fcp_pkg::ACT_RIGHT: dir_nxt = fcp_pkg::DIR_RIGHT;
              default:            dir_nxt = fcp_pkg::DIR_BACK;
            endcase
            applied_nxt = speed_r;
            standby_nxt = 1'b1;
            send_ctrl   = 1'b1;
          end
          fcp_pkg::ACT_SPEED: begin
            if (data_r != 8'd0 && data_r <= fcp_pkg::SPEED_TOP) begin
              speed_nxt = (dsum > {2'b00, fcp_pkg::DUTY_TOP}) ? fcp_pkg::DUTY_TOP
                                                              : dsum[12:0];
              send_ctrl = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      cnt_nxt = 3'd0;
    end
  end

  assign ctrl_sum = fcp_pkg::REPLY_A + fcp_pkg::REPLY_B + 8'(fcp_pkg::FRAME_LENGTH)
                  + fcp_pkg::TYPE_CTRL + act_r + status;
  assign temp_sum = fcp_pkg::REPLY_A + fcp_pkg::REPLY_B + fcp_pkg::TEMP_LEN_BYTE
                  + fcp_pkg::TYPE_TEMP + rep_act + item.temperature[15:8]
                  + item.temperature[7:0];

  always_comb begin
    reply_en = go && (send_ctrl || send_temp);
    reply.motor.standby   = standby_nxt;
    reply.motor.direction = dir_nxt;
    reply.motor.duty      = applied_nxt;
    reply.bytes[0] = fcp_pkg::REPLY_A;
    reply.bytes[1] = fcp_pkg::REPLY_B;
    if (send_temp) begin
      reply.len      = fcp_pkg::LEN_W'(8);
      reply.bytes[2] = fcp_pkg::TEMP_LEN_BYTE;
      reply.bytes[3] = fcp_pkg::TYPE_TEMP;
      reply.bytes[4] = rep_act;
      reply.bytes[5] = item.temperature[15:8];
      reply.bytes[6] = item.temperature[7:0];
      reply.bytes[7] = temp_sum;
    end else begin
      reply.len      = fcp_pkg::LEN_W'(fcp_pkg::FRAME_LENGTH);
      reply.bytes[2] = 8'(fcp_pkg::FRAME_LENGTH);
      reply.bytes[3] = fcp_pkg::TYPE_CTRL;
      reply.bytes[4] = act_r;
      reply.bytes[5] = status;
      reply.bytes[6] = ctrl_sum;
      reply.bytes[7] = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      sum_r     <= '0;
      speed_r   <= fcp_pkg::DUTY_INIT_RESET;
      applied_r <= fcp_pkg::DUTY_INIT_RESET;
      dir_r     <= fcp_pkg::DIR_RESET;
      standby_r <= 1'b0;
    end else if (go) begin
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      speed_r   <= speed_nxt;
      applied_r <= applied_nxt;
      dir_r     <= dir_nxt;
      standby_r <= standby_nxt;
    end
  end

  // frame body bytes, only read after the current frame wrote them
  always_ff @(posedge clk) begin
    if (go) begin
      type_r <= type_nxt;
      act_r  <= act_nxt;
      data_r <= data_nxt;
    end
  end

endmodule

@@ hw/rtl/fcp_reply_tx.sv @@
// reply frame shift register, one byte per output beat
`timescale 1ns / 1ps

module fcp_reply_tx (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  fcp_pkg::reply_t             reply,
  output logic                        free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_reply_byte,
  output logic                        out_reply_last,
  output logic                        out_motor_standby,
  output logic [7:0]                  out_motor_direction,
  output logic [fcp_pkg::DUTY_W-1:0]  out_motor_duty
);

  logic [fcp_pkg::REPLY_MAX-1:0][7:0] shift_r;
  logic [fcp_pkg::LEN_W-1:0]          left_r;
  fcp_pkg::motor_t                    motor_r;
  logic                               beat;

  assign beat      = out_valid && out_ready;
  assign out_valid = (left_r != '0);
  // room for a new frame once the last byte leaves
  assign free      = (left_r == '0) || (left_r == fcp_pkg::LEN_W'(1) && out_ready);

  assign out_reply_byte      = shift_r[0];
  assign out_reply_last      = (left_r == fcp_pkg::LEN_W'(1));
  assign out_motor_standby   = motor_r.standby;
  assign out_motor_direction = motor_r.direction;
  assign out_motor_duty      = motor_r.duty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (load) begin
      left_r <= reply.len;
    end else if (beat) begin
      left_r <= left_r - fcp_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift_r <= reply.bytes;
      motor_r <= reply.motor;
    end else if (beat) begin
      shift_r <= {8'h00, shift_r[fcp_pkg::REPLY_MAX-1:1]};
    end
  end

endmodule

@@ hw/rtl/fcp_checker.sv @@
// port checker for the framed command parser, bound to the top level
`timescale 1ns / 1ps

module fcp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [7:0]                  out_reply_byte,
  input logic                        out_reply_last,
  input logic                        out_motor_standby,
  input logic [7:0]                  out_motor_direction,
  input logic [fcp_pkg::DUTY_W-1:0]  out_motor_duty
);

  logic first_r;

  // high while the next output beat opens a reply frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      first_r <= out_reply_last;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reply_byte)
                                && $stable(out_reply_last))
    else $error("stalled reply beat changed");

  a_frame_go_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_reply_last |=> out_valid
      && $stable(out_motor_duty) && $stable(out_motor_direction)
      && $stable(out_motor_standby))
    else $error("reply frame broken or motor state changed mid frame");

  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r |-> out_reply_byte == fcp_pkg::REPLY_A && !out_reply_last)
    else $error("reply frame does not open with header byte");

  a_duty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_motor_duty <= fcp_pkg::DUTY_TOP)
    else $error("applied duty above top");

endmodule

bind framed_command_parser_with_reply_unit fcp_checker u_fcp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_reply_byte      (out_reply_byte),
  .out_reply_last      (out_reply_last),
  .out_motor_standby   (out_motor_standby),
  .out_motor_direction (out_motor_direction),
  .out_motor_duty      (out_motor_duty)
);

@@ tb/tb_framed_command_parser_with_reply_unit.sv @@
// testbench for the framed command parser: predicted reply bytes checked under random flow control
`timescale 1ns / 1ps

module tb_framed_command_parser_with_reply_unit;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_LIMIT    = 5000;

  typedef struct packed {
    logic [7:0]                 rbyte;
    logic                       last;
    logic                       standby;
    logic [7:0]                 direction;
    logic [fcp_pkg::DUTY_W-1:0] duty;
  } reply_beat_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_kind = 1'b0;
  logic [7:0]                 in_rx_byte = 8'h00;
  logic [15:0]                in_temperature = 16'h0000;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [7:0]                 out_reply_byte;
  logic                       out_reply_last;
  logic                       out_motor_standby;
  logic [7:0]                 out_motor_direction;
  logic [fcp_pkg::DUTY_W-1:0] out_motor_duty;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = 2'b00;
  logic [fcp_pkg::DUTY_W-1:0] cfg_data = '0;

  framed_command_parser_with_reply_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_rx_byte          (in_rx_byte),
    .in_temperature      (in_temperature),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_reply_byte      (out_reply_byte),
    .out_reply_last      (out_reply_last),
    .out_motor_standby   (out_motor_standby),
    .out_motor_direction (out_motor_direction),
    .out_motor_duty      (out_motor_duty),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // parser and motor state as the block should hold it
  logic [2:0]                 hunt_pos;
  logic [7:0]                 cmd_bytes [fcp_pkg::FRAME_LENGTH];
  logic [7:0]                 cmd_sum;
  logic [fcp_pkg::DUTY_W-1:0] speed_duty;
  logic [fcp_pkg::DUTY_W-1:0] applied_duty;
  logic [7:0]                 dir_pins;
  logic                       standby_en;
  logic [fcp_pkg::DUTY_W-1:0] duty_min_r;
  logic [fcp_pkg::STEP_W-1:0] duty_step_r;

  reply_beat_t reply_q [$];
  reply_beat_t want;

  int errors = 0;
  int items_sent = 0;
  int bytes_seen = 0;
  int ctrl_frames = 0;
  int temp_frames = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] rnd_temp();
    return 16'($urandom_range(0, 65535));
  endfunction

  // every reply frame ends in the sum of its earlier bytes
  function automatic void queue_frame(input logic [7:0] fr [8], input int len);
    logic [7:0]  s;
    reply_beat_t beat;
    int          i;
    s = 8'h00;
    for (i = 0; i < len - 1; i++) s += fr[i];
    for (i = 0; i < len; i++) begin
      beat.rbyte     = (i == len - 1) ? s : fr[i];
      beat.last      = (i == len - 1);
      beat.standby   = standby_en;
      beat.direction = dir_pins;
      beat.duty      = applied_duty;
      reply_q.push_back(beat);
    end
  endfunction

  function automatic void queue_temp(input logic [7:0] act, input logic [15:0] t);
    logic [7:0] fr [8];
    fr = '{fcp_pkg::REPLY_A, fcp_pkg::REPLY_B, fcp_pkg::TEMP_LEN_BYTE, fcp_pkg::TYPE_TEMP,
           act, t[15:8], t[7:0], 8'h00};
    queue_frame(fr, 8);
    temp_frames++;
  endfunction

  function automatic void queue_ctrl(input logic [7:0] status);
    logic [7:0] fr [8];
    fr = '{fcp_pkg::REPLY_A, fcp_pkg::REPLY_B, cmd_bytes[2], fcp_pkg::TYPE_CTRL,
           cmd_bytes[4], status, 8'h00, 8'h00};
    queue_frame(fr, 7);
    ctrl_frames++;
  endfunction

  function automatic void run_motor_cmd();
    logic        ok;
    logic [31:0] d;
    ok = 1'b1;
    case (cmd_bytes[4])
      fcp_pkg::ACT_STOP:  standby_en = 1'b0;
      fcp_pkg::ACT_FWD:   dir_pins = fcp_pkg::DIR_FWD;
      fcp_pkg::ACT_LEFT:  dir_pins = fcp_pkg::DIR_LEFT;
      fcp_pkg::ACT_RIGHT: dir_pins = fcp_pkg::DIR_RIGHT;
      fcp_pkg::ACT_BACK:  dir_pins = fcp_pkg::DIR_BACK;
      fcp_pkg::ACT_SPEED: begin
        if (cmd_bytes[5] >= 8'd1 && cmd_bytes[5] <= fcp_pkg::SPEED_TOP) begin
          d = duty_min_r + duty_step_r * cmd_bytes[5];
          speed_duty = (d > fcp_pkg::DUTY_TOP) ? fcp_pkg::DUTY_TOP : d[fcp_pkg::DUTY_W-1:0];
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase
    if (ok && cmd_bytes[4] >= fcp_pkg::ACT_FWD && cmd_bytes[4] <= fcp_pkg::ACT_BACK) begin
      applied_duty = speed_duty;
      standby_en   = 1'b1;
    end
    if (ok) queue_ctrl(fcp_pkg::STATUS_OK);
  endfunction

  function automatic void predict_beat(input logic k, input logic [7:0] b,
                                       input logic [15:0] t);
    if (k) begin
      queue_temp(fcp_pkg::ACT_REPORT, t);
      return;
    end
    case (hunt_pos)
      3'd0: begin
        if (b == fcp_pkg::HEAD_A) begin
          cmd_bytes[0] = b;
          cmd_sum      = b;
          hunt_pos     = 3'd1;
        end
      end
      3'd1: begin
        if (b == fcp_pkg::HEAD_B) begin
          cmd_bytes[1] = b;
          cmd_sum     += b;
          hunt_pos     = 3'd2;
        end else if (b == fcp_pkg::HEAD_A) begin
          cmd_bytes[0] = b;
          cmd_sum      = b;
          hunt_pos     = 3'd1;
        end else begin
          hunt_pos = 3'd0;
        end
      end
      3'd2: begin
        if (b == 8'(fcp_pkg::FRAME_LENGTH)) begin
          cmd_bytes[2] = b;
          cmd_sum     += b;
          hunt_pos     = 3'd3;
        end else begin
          hunt_pos = 3'd0;
        end
      end
      3'd3, 3'd4, 3'd5: begin
        cmd_bytes[hunt_pos] = b;
        cmd_sum            += b;
        hunt_pos            = hunt_pos + 3'd1;
      end
      3'd6: begin
        // checksum byte closes the frame
        cmd_bytes[6] = b;
        hunt_pos     = 3'd0;
        if (cmd_sum != b) begin
          if (cmd_bytes[3] == fcp_pkg::TYPE_CTRL) queue_ctrl(fcp_pkg::STATUS_BADSUM);
          else if (cmd_bytes[3] == fcp_pkg::TYPE_TEMP) queue_temp(cmd_bytes[4], t);
        end else if (cmd_bytes[3] == fcp_pkg::TYPE_TEMP) begin
          queue_temp(cmd_bytes[4], t);
        end else if (cmd_bytes[3] == fcp_pkg::TYPE_CTRL) begin
          run_motor_cmd();
        end
      end
      default: hunt_pos = 3'd0;
    endcase
  endfunction

  task automatic send_item(input logic k, input logic [7:0] b, input logic [15:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_rx_byte     <= b;
    in_temperature <= t;
    do @(posedge clk); while (!in_ready);
    predict_beat(k, b, t);
    items_sent++;
  endtask

  // full command frame; corrupt spoils the checksum, mix slips report requests in
  task automatic send_cmd(input logic [7:0] typ, input logic [7:0] act, input logic [7:0] data,
                          input bit corrupt, input bit mix);
    logic [7:0] fr [7];
    logic [7:0] s;
    int         i;
    fr = '{fcp_pkg::HEAD_A, fcp_pkg::HEAD_B, 8'(fcp_pkg::FRAME_LENGTH), typ, act, data, 8'h00};
    s  = 8'h00;
    for (i = 0; i < 6; i++) s += fr[i];
    fr[6] = corrupt ? (s ^ 8'($urandom_range(1, 255))) : s;
    for (i = 0; i < 7; i++) begin
      if (mix && $urandom_range(0, 19) == 0) send_item(1'b1, rnd_byte(), rnd_temp());
      send_item(1'b0, fr[i], rnd_temp());
    end
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    // items with no reply may still sit in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_duty_regs(input logic [fcp_pkg::DUTY_W-1:0] dmin,
                               input logic [fcp_pkg::STEP_W-1:0] dstep,
                               input logic [fcp_pkg::DUTY_W-1:0] dinit);
    wait_for_replies();
    cfg_valid <= 1'b1;
    cfg_index <= fcp_pkg::CFG_DUTY_MIN;
    cfg_data  <= dmin;
    do @(posedge clk); while (!cfg_ready);
    duty_min_r = dmin;
    cfg_index <= fcp_pkg::CFG_DUTY_STEP;
    cfg_data  <= fcp_pkg::DUTY_W'(dstep);
    do @(posedge clk); while (!cfg_ready);
    duty_step_r = dstep;
    // the block accepts the initial duty but does not store it
    cfg_index <= fcp_pkg::CFG_DUTY_INIT;
    cfg_data  <= dinit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_report_requests();
    send_item(1'b1, 8'h00, 16'h0000);
    send_item(1'b1, 8'hFF, 16'hFFFF);
    send_item(1'b1, fcp_pkg::HEAD_A, 16'hA55A);
  endtask

  task automatic test_header_hunt();
    // a second FE restarts the frame
    send_item(1'b0, fcp_pkg::HEAD_A, rnd_temp());
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_FWD, 8'h00, 1'b0, 1'b0);
    send_item(1'b0, fcp_pkg::HEAD_A, rnd_temp());
    send_item(1'b0, 8'h00, rnd_temp());
    // wrong length bytes
    send_item(1'b0, fcp_pkg::HEAD_A, rnd_temp());
    send_item(1'b0, fcp_pkg::HEAD_B, rnd_temp());
    send_item(1'b0, 8'h06, rnd_temp());
    send_item(1'b0, fcp_pkg::HEAD_A, rnd_temp());
    send_item(1'b0, fcp_pkg::HEAD_B, rnd_temp());
    send_item(1'b0, fcp_pkg::HEAD_A, rnd_temp());
  endtask

  task automatic test_motor_actions();
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_SPEED, fcp_pkg::SPEED_TOP, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_FWD, rnd_byte(), 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_LEFT, rnd_byte(), 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_STOP, rnd_byte(), 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_SPEED, 8'd1, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_RIGHT, rnd_byte(), 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_BACK, rnd_byte(), 1'b0, 1'b0);
  endtask

  task automatic test_bad_frames();
    send_cmd(fcp_pkg::TYPE_CTRL, 8'd6, 8'h10, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, 8'hFF, 8'h10, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_SPEED, 8'd0, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_SPEED, 8'd101, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_SPEED, 8'hFF, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_LEFT, 8'h00, 1'b1, 1'b0);
    send_cmd(fcp_pkg::TYPE_TEMP, 8'h5A, 8'h00, 1'b1, 1'b0);
    send_cmd(8'h03, fcp_pkg::ACT_FWD, 8'h00, 1'b1, 1'b0);
    send_cmd(8'h00, fcp_pkg::ACT_FWD, 8'h00, 1'b0, 1'b0);
    send_cmd(8'hFF, fcp_pkg::ACT_BACK, 8'h00, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_TEMP, 8'h00, 8'hFF, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_TEMP, 8'hFF, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_duty_registers();
    // top of range saturates, zero step and minimum give zero duty, one step from zero gives 40
    set_duty_regs(13'd4096, 6'd40, 13'd0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_SPEED, fcp_pkg::SPEED_TOP, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_FWD, 8'h00, 1'b0, 1'b0);
    set_duty_regs(13'd0, 6'd0, 13'd4096);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_SPEED, 8'd50, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_BACK, 8'h00, 1'b0, 1'b0);
    set_duty_regs(13'd0, 6'd40, 13'd1);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_SPEED, 8'd1, 1'b0, 1'b0);
    send_cmd(fcp_pkg::TYPE_CTRL, fcp_pkg::ACT_RIGHT, 8'h00, 1'b0, 1'b0);
    set_duty_regs(fcp_pkg::DUTY_MIN_RESET, fcp_pkg::DUTY_STEP_RESET, fcp_pkg::DUTY_INIT_RESET);
  endtask

  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs++;
    for (i = 0; i < 4; i++) begin
      send_cmd(fcp_pkg::TYPE_TEMP, rnd_byte(), rnd_byte(), 1'b0, 1'b0);
      send_item(1'b1, rnd_byte(), rnd_temp());
    end
    wait_for_replies();
  endtask

  task automatic send_random_cmd();
    logic [7:0] typ;
    logic [7:0] act;
    logic [7:0] data;
    int         r;
    r   = $urandom_range(0, 99);
    typ = (r < 60) ? fcp_pkg::TYPE_CTRL : (r < 85) ? fcp_pkg::TYPE_TEMP : rnd_byte();
    act = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 5)) : rnd_byte();
    if (act == fcp_pkg::ACT_SPEED && $urandom_range(0, 9) < 8) data = 8'($urandom_range(1, 100));
    else data = rnd_byte();
    send_cmd(typ, act, data, $urandom_range(0, 9) == 0, 1'b1);
  endtask

  task automatic send_broken_frame();
    logic [7:0] b;
    int         i;
    int         cut;
    case ($urandom_range(0, 2))
      0: begin
        b = rnd_byte();
        if (b == fcp_pkg::HEAD_A || b == fcp_pkg::HEAD_B) b = 8'h00;
        send_item(1'b0, fcp_pkg::HEAD_A, rnd_temp());
        send_item(1'b0, b, rnd_temp());
      end
      1: begin
        b = rnd_byte();
        if (b == 8'(fcp_pkg::FRAME_LENGTH)) b = 8'h08;
        send_item(1'b0, fcp_pkg::HEAD_A, rnd_temp());
        send_item(1'b0, fcp_pkg::HEAD_B, rnd_temp());
        send_item(1'b0, b, rnd_temp());
      end
      default: begin
        // frame cut short, the next item lands in its unfinished header or body
        cut = $urandom_range(1, 6);
        for (i = 0; i < cut; i++) begin
          case (i)
            0:       b = fcp_pkg::HEAD_A;
            1:       b = fcp_pkg::HEAD_B;
            2:       b = 8'(fcp_pkg::FRAME_LENGTH);
            3:       b = fcp_pkg::TYPE_CTRL;
            default: b = rnd_byte();
          endcase
          send_item(1'b0, b, rnd_temp());
        end
      end
    endcase
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
    int stop_at;
    int pick;
    int i;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_random_cmd();
      end else if (pick < 80) begin
        for (i = $urandom_range(1, 4); i > 0; i--) send_item(1'b0, rnd_byte(), rnd_temp());
      end else if (pick < 94) begin
        send_broken_frame();
      end else begin
        send_item(1'b1, rnd_byte(), rnd_temp());
      end
    end
  endtask

  // receiver: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left  = hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      out_ready   <= 1'b0;
      hold_served  = hold_served + 1;
      hold_left    = HOLD_CYCLES;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      bytes_seen++;
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: reply byte %02h with nothing expected", $time, out_reply_byte);
      end else begin
        want = reply_q.pop_front();
        if (out_reply_byte !== want.rbyte) begin
          errors++;
          $display("%0t: reply_byte expected %02h got %02h", $time, want.rbyte, out_reply_byte);
        end
        if (out_reply_last !== want.last) begin
          errors++;
          $display("%0t: reply_last expected %0b got %0b", $time, want.last, out_reply_last);
        end
        if (out_motor_standby !== want.standby) begin
          errors++;
          $display("%0t: motor_standby expected %0b got %0b", $time, want.standby,
                   out_motor_standby);
        end
        if (out_motor_direction !== want.direction) begin
          errors++;
          $display("%0t: motor_direction expected %02h got %02h", $time, want.direction,
                   out_motor_direction);
        end
        if (out_motor_duty !== want.duty) begin
          errors++;
          $display("%0t: motor_duty expected %0d got %0d", $time, want.duty, out_motor_duty);
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d replies outstanding", $time, IDLE_LIMIT,
                 reply_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    hunt_pos     = 3'd0;
    cmd_sum      = 8'h00;
    speed_duty   = fcp_pkg::DUTY_INIT_RESET;
    applied_duty = fcp_pkg::DUTY_INIT_RESET;
    dir_pins     = fcp_pkg::DIR_RESET;
    standby_en   = 1'b0;
    duty_min_r   = fcp_pkg::DUTY_MIN_RESET;
    duty_step_r  = fcp_pkg::DUTY_STEP_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_report_requests();
    test_header_hunt();
    test_motor_actions();
    test_bad_frames();
    test_duty_registers();
    test_backpressure();

    test_random_traffic(0, 0, 60);
    set_duty_regs(13'd0, 6'd0, 13'd0);
    test_random_traffic(57, 0, 60);
    set_duty_regs(13'd4096, 6'd40, 13'd4096);
    test_random_traffic(0, 57, 60);
    set_duty_regs(13'($urandom_range(0, 4096)), 6'($urandom_range(0, 40)),
                  13'($urandom_range(0, 4096)));
    test_random_traffic(22, 22, 64);

    wait_for_replies();
    $display("sent %0d input beats, checked %0d reply bytes (%0d control, %0d temp frames)",
             items_sent, bytes_seen, ctrl_frames, temp_frames);
    $display("header hunt, bad sums and actions, duty limits, four flow phases, long output hold");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/fcp_pkg.sv
hw/rtl/fcp_parser.sv
hw/rtl/fcp_reply_tx.sv
hw/rtl/framed_command_parser_with_reply_unit.sv
hw/rtl/fcp_checker.sv
tb/tb_framed_command_parser_with_reply_unit.sv
